// ===== design/pet_pkg.sv =====
// ----------------------------------------------------------------------------
// pet_pkg
// Shared constants and types for the Prewitt edge threshold block.
// ----------------------------------------------------------------------------
package pet_pkg;

    // Frame geometry: square frames of IMAGE_SIZE x IMAGE_SIZE pixels.
    localparam int IMAGE_SIZE = 256;
    localparam int COL_W      = $clog2(IMAGE_SIZE);
    localparam int OWED_W     = $clog2(IMAGE_SIZE + 1);

    // Pixel and arithmetic widths.
    localparam int PIX_W    = 8;
    localparam int SUM_W    = PIX_W + 2;
    localparam int GRAD_W   = SUM_W + 1;
    localparam int SQ_W     = 2 * GRAD_W - 2;
    localparam int MAG_W    = SQ_W + 1;
    localparam int THR_W    = 11;
    localparam int LIM_W    = THR_W + 1;
    localparam int LIM_SQ_W = 2 * LIM_W - 1;

    // Line store entry holds the newer row above the older row.
    localparam int LINE_W = 2 * PIX_W;

    localparam logic [PIX_W-1:0] WHITE = PIX_W'(255);
    localparam logic [PIX_W-1:0] BLACK = PIX_W'(0);

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(180);
    localparam logic [LIM_SQ_W-1:0] LIM_SQ_RESET =
        LIM_SQ_W'((180 + 1) * (180 + 1));

    // Configuration port.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int REG_INDEX_W = ADDR_W - 2;
    localparam logic [REG_INDEX_W-1:0] REG_EDGE_THRESHOLD = REG_INDEX_W'(0);

    // Input word kinds.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Control that travels with each word through the pipeline.
    typedef struct packed {
        logic valid;     // stage holds a word
        logic is_pixel;  // word updates the line store and window
        logic has_res;   // word produces at least one result
        logic border;    // first result is forced white
        logic second;    // a white border result follows the first
        logic last0;     // tlast of the first result
        logic fend;      // frame end marker of the first result
    } pet_ctrl_t;

endpackage

// ===== design/prewitt_edge_threshold.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_threshold
// Streaming 3x3 Prewitt edge detector with a programmable magnitude threshold.
// ----------------------------------------------------------------------------
// Usage:
// Pixels of a square frame enter in raster order on the slave stream, one
// word per pixel with s_axis_tuser = 0. A word with s_axis_tuser = 1 is a
// flush word. Results leave on the master stream: 0 marks an edge, 255 marks
// no edge or a border pixel. Results lag the input by one row and one column.
// The last pixel of rows 1 and up gives two results (the second is the white
// border column). After the last pixel of a frame, IMAGE_SIZE flush words
// each release one white pixel of the bottom border row; the final one has
// m_axis_tuser set. Pixel words that arrive while that row is still owed are
// dropped, and flush words with nothing owed produce nothing.
// Throughput is one word per cycle while the receiver keeps up; the column-end
// word yields two results, and the input is held while the second is pending.
// A taken word passes the line store read, the gradient register, the square
// register and then the compare into the output register.
// If the receiver stalls, the whole pipeline holds and s_axis_tready falls;
// the output register still lets the next word in while a result is taken.
// Reset restores the threshold to 180 and the frame position to the start;
// the line store contents are left as they are and only feed border results.
// The threshold register is written over APB at address 0.
// ----------------------------------------------------------------------------
module prewitt_edge_threshold
    import pet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // Slave stream. tdata: pixel[7:0]. tuser: func[0].
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic [0:0]        s_axis_tuser,

    // Master stream. tdata: edge_pixel[7:0]. tlast: last_of_run.
    // tuser: frame_end[0].
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast,
    output logic [0:0]        m_axis_tuser,

    // APB configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration. The squared limit is computed once at write time so
    // the per-pixel compare needs no multiplier of its own.
    // ------------------------------------------------------------------
    logic [THR_W-1:0]    thr_reg;
    logic [LIM_SQ_W-1:0] lim_sq_reg;
    logic                cfg_we;
    logic [LIM_W-1:0]    lim_next;
    logic [2*LIM_W-1:0]  lim_sq_full;

    assign pready      = 1'b1;
    assign cfg_we      = psel && penable && pwrite &&
                         (paddr[ADDR_W-1:2] == REG_EDGE_THRESHOLD);
    assign lim_next    = {1'b0, pwdata[THR_W-1:0]} + LIM_W'(1);
    assign lim_sq_full = lim_next * lim_next;
    assign prdata      = (paddr[ADDR_W-1:2] == REG_EDGE_THRESHOLD) ?
                         DATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RESET;
            lim_sq_reg <= LIM_SQ_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg    <= pwdata[THR_W-1:0];
            lim_sq_reg <= lim_sq_full[LIM_SQ_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves together; the output register
    // frees up in the same cycle its single result is taken.
    // ------------------------------------------------------------------
    logic o_valid_reg;
    logic o_second_reg;
    logic adv;
    logic s_hs;
    logic m_hs;

    assign adv           = !o_valid_reg || (m_axis_tready && !o_second_reg);
    assign s_axis_tready = adv;
    assign s_hs          = s_axis_tvalid && adv;
    assign m_hs          = m_axis_tvalid && m_axis_tready;

    // ------------------------------------------------------------------
    // Stage 0: classify the incoming word against the frame position and
    // the count of owed border results, and issue the line store read.
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [OWED_W-1:0] owed_reg, owed_next;
    pet_ctrl_t         enter_ctrl;
    logic              is_flush;
    logic              col_last;
    logic              row_last;

    assign is_flush = (s_axis_tuser[0] == FUNC_FLUSH);
    assign col_last = (col_reg == COL_W'(IMAGE_SIZE - 1));
    assign row_last = (row_reg == COL_W'(IMAGE_SIZE - 1));

    always_comb
    begin
        enter_ctrl = '0;
        row_next   = row_reg;
        col_next   = col_reg;
        owed_next  = owed_reg;
        if (s_hs)
        begin
            if (is_flush && (owed_reg != '0))
            begin
                enter_ctrl.valid   = 1'b1;
                enter_ctrl.has_res = 1'b1;
                enter_ctrl.border  = 1'b1;
                enter_ctrl.last0   = 1'b1;
                enter_ctrl.fend    = (owed_reg == OWED_W'(1));
                owed_next          = owed_reg - OWED_W'(1);
            end
            else if (!is_flush && (owed_reg == '0))
            begin
                enter_ctrl.valid    = 1'b1;
                enter_ctrl.is_pixel = 1'b1;
                enter_ctrl.has_res  = (row_reg != '0) && (col_reg != '0);
                enter_ctrl.border   = (row_reg == COL_W'(1)) || (col_reg == COL_W'(1));
                enter_ctrl.second   = col_last;
                enter_ctrl.last0    = !col_last;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        row_next  = '0;
                        owed_next = OWED_W'(IMAGE_SIZE);
                    end
                    else
                    begin
                        row_next = row_reg + COL_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            owed_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            owed_reg <= owed_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one entry per column holding the two rows above the
    // current one. It is read when a pixel enters and written back when the
    // pipeline next advances, with the read data in hand. Consecutive pixels
    // touch neighboring columns, so a read never meets a pending write.
    // ------------------------------------------------------------------
    pet_ctrl_t        s1_ctrl_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             ram_we;
    logic             ram_re;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] ram_wdata;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;

    assign ram_re    = enter_ctrl.is_pixel;
    assign ram_we    = adv && s1_ctrl_reg.valid && s1_ctrl_reg.is_pixel;
    assign top       = ram_rdata[PIX_W-1:0];
    assign mid       = ram_rdata[LINE_W-1:PIX_W];
    assign ram_wdata = {s1_pix_reg, mid};

    pet_ram #(
        .WIDTH (LINE_W),
        .DEPTH (IMAGE_SIZE)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctrl_reg <= enter_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg <= s_axis_tdata[PIX_W-1:0];
            s1_col_reg <= col_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window of the two previous columns plus the current column
    // (top, mid, pixel) gives the Prewitt gradients.
    // Window order: w0..w2 column c-2, w3..w5 column c-1, top to bottom.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [6];
    logic [SUM_W-1:0] left_sum, right_sum, upper_sum, lower_sum;
    logic signed [GRAD_W-1:0] gx_next, gy_next;

    assign left_sum  = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2]);
    assign right_sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_pix_reg);
    assign upper_sum = SUM_W'(win_reg[0]) + SUM_W'(win_reg[3]) + SUM_W'(top);
    assign lower_sum = SUM_W'(win_reg[2]) + SUM_W'(win_reg[5]) + SUM_W'(s1_pix_reg);
    assign gx_next   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign gy_next   = $signed({1'b0, lower_sum}) - $signed({1'b0, upper_sum});

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_pix_reg;
        end
    end

    pet_ctrl_t                s2_ctrl_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the gradients.
    // ------------------------------------------------------------------
    pet_ctrl_t                  s3_ctrl_reg;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg;
    logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;

    assign sqx_full = gx_reg * gx_reg;
    assign sqy_full = gy_reg * gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            s3_ctrl_reg <= s2_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= sqx_full[SQ_W-1:0];
            sqy_reg <= sqy_full[SQ_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitude compare into the output register. A column-end
    // word leaves its second (white) result pending until the first is taken.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag_sq;
    logic [PIX_W-1:0] val_next;
    logic             load_out;
    logic [PIX_W-1:0] o_val_reg;
    logic             o_last_reg;
    logic             o_fend_reg;

    assign mag_sq   = MAG_W'(sqx_reg) + MAG_W'(sqy_reg);
    assign val_next = s3_ctrl_reg.border ? WHITE :
                      ((LIM_SQ_W'(mag_sq) >= lim_sq_reg) ? BLACK : WHITE);
    assign load_out = adv && s3_ctrl_reg.valid && s3_ctrl_reg.has_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg  <= 1'b0;
            o_second_reg <= 1'b0;
        end
        else if (m_hs && o_second_reg)
        begin
            o_second_reg <= 1'b0;
        end
        else if (load_out)
        begin
            o_valid_reg  <= 1'b1;
            o_second_reg <= s3_ctrl_reg.second;
        end
        else if (m_hs)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_hs && o_second_reg)
        begin
            o_val_reg  <= WHITE;
            o_last_reg <= 1'b1;
            o_fend_reg <= 1'b0;
        end
        else if (load_out)
        begin
            o_val_reg  <= val_next;
            o_last_reg <= s3_ctrl_reg.last0;
            o_fend_reg <= s3_ctrl_reg.fend;
        end
    end

    assign m_axis_tvalid   = o_valid_reg;
    assign m_axis_tdata    = o_val_reg;
    assign m_axis_tlast    = o_last_reg;
    assign m_axis_tuser[0] = o_fend_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_second_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        o_second_reg |-> o_valid_reg)
        else $error("pending second result without a valid output word");

    a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("frame end marked on a word that does not close its run");

    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg <= OWED_W'(IMAGE_SIZE))
        else $error("owed border count above the frame width");

    a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (s1_col_reg != col_reg))
        else $error("line store read and write hit the same column");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_hs && o_second_reg) |=>
            (m_axis_tvalid && m_axis_tlast && (m_axis_tdata == WHITE)))
        else $error("border column result missing after column end");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_second_reg) |-> !s_axis_tready)
        else $error("input taken while a second result is still pending");

endmodule

// ===== design/pet_ram.sv =====
// ----------------------------------------------------------------------------
// pet_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sim/edge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_checker
// Watches both streams and the APB port of the Prewitt edge threshold block,
// keeps its own copy of the line stores, window and frame position, predicts
// every result word and compares each delivered word field by field.
// ----------------------------------------------------------------------------
module edge_checker
    import pet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic [0:0]        s_axis_tuser,

    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [7:0]        m_axis_tdata,
    input  logic              m_axis_tlast,
    input  logic [0:0]        m_axis_tuser,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,

    output int unsigned       mismatches,
    output int unsigned       pending,
    output int unsigned       results_seen,
    output int unsigned       edges_seen
);

    typedef struct packed {
        logic [PIX_W-1:0] edge_pixel;
        logic             last_of_run;
        logic             frame_end;
    } edge_result_t;

    edge_result_t     expected_edges[$];
    logic [THR_W-1:0] threshold = THRESHOLD_RESET;

    // Rows r-2 and r-1, and the two window columns left of the newest pixel
    // (index 0 is the top of a column).
    logic [PIX_W-1:0] two_rows_up [IMAGE_SIZE];
    logic [PIX_W-1:0] one_row_up  [IMAGE_SIZE];
    logic [PIX_W-1:0] col_far     [3];
    logic [PIX_W-1:0] col_near    [3];

    int          row_at = 0;
    int          col_at = 0;
    int          border_owed = 0;
    int unsigned error_total = 0;
    int unsigned result_total = 0;
    int unsigned edge_total = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        error_total++;
        $display("MISMATCH at %0t ns, result %0d: %s is %0d, expected %0d",
                 $time, result_total, what, got, want);
    endtask

    function automatic logic [PIX_W-1:0] edge_verdict(input int t, input int m, input int b);
        int gx;
        int gy;
        int limit;
        gx = (t + m + b) - (col_far[0] + col_far[1] + col_far[2]);
        gy = (col_far[2] + col_near[2] + b) - (col_far[0] + col_near[0] + t);
        limit = int'(threshold) + 1;
        return (gx * gx + gy * gy >= limit * limit) ? BLACK : WHITE;
    endfunction

    task automatic predict_word(input logic func, input logic [PIX_W-1:0] pix);
        int           top;
        int           mid;
        edge_result_t res;
        if (func == FUNC_FLUSH)
        begin
            if (border_owed != 0)
            begin
                border_owed--;
                res.edge_pixel  = WHITE;
                res.last_of_run = 1'b1;
                res.frame_end   = (border_owed == 0);
                expected_edges.push_back(res);
            end
        end
        else if (border_owed == 0)
        begin
            top = two_rows_up[col_at];
            mid = one_row_up[col_at];
            two_rows_up[col_at] = PIX_W'(mid);
            one_row_up[col_at]  = pix;
            if (row_at >= 1 && col_at >= 1)
            begin
                // The window center is one row up and one column left.
                if (row_at == 1 || col_at == 1)
                    res.edge_pixel = WHITE;
                else
                    res.edge_pixel = edge_verdict(top, mid, int'(pix));
                res.last_of_run = (col_at != IMAGE_SIZE - 1);
                res.frame_end   = 1'b0;
                expected_edges.push_back(res);
                if (col_at == IMAGE_SIZE - 1)
                begin
                    res.edge_pixel  = WHITE;
                    res.last_of_run = 1'b1;
                    expected_edges.push_back(res);
                end
            end
            col_far     = col_near;
            col_near[0] = PIX_W'(top);
            col_near[1] = PIX_W'(mid);
            col_near[2] = pix;
            if (col_at == IMAGE_SIZE - 1)
            begin
                col_at = 0;
                if (row_at == IMAGE_SIZE - 1)
                begin
                    row_at      = 0;
                    border_owed = IMAGE_SIZE;
                end
                else
                begin
                    row_at++;
                end
            end
            else
            begin
                col_at++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        edge_result_t want;
        if (!rst_n)
        begin
            expected_edges.delete();
            threshold   = THRESHOLD_RESET;
            row_at      = 0;
            col_at      = 0;
            border_owed = 0;
            foreach (two_rows_up[i])
            begin
                two_rows_up[i] = '0;
                one_row_up[i]  = '0;
            end
            col_far  = '{default: '0};
            col_near = '{default: '0};
        end
        else
        begin
            if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_EDGE_THRESHOLD)
            begin
                if (pwrite)
                    threshold = pwdata[THR_W-1:0];
                else if (prdata != DATA_W'(threshold))
                    report_mismatch("threshold readback", int'(prdata), int'(threshold));
            end

            // Results leave before new words can produce any, so pop first.
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_total++;
                if (expected_edges.size() == 0)
                begin
                    report_mismatch("unexpected result word, edge_pixel", int'(m_axis_tdata),
                                    -1);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (m_axis_tdata != want.edge_pixel)
                        report_mismatch("edge_pixel", int'(m_axis_tdata), int'(want.edge_pixel));
                    if (m_axis_tlast != want.last_of_run)
                        report_mismatch("last_of_run", int'(m_axis_tlast),
                                        int'(want.last_of_run));
                    if (m_axis_tuser[0] != want.frame_end)
                        report_mismatch("frame_end", int'(m_axis_tuser[0]), int'(want.frame_end));
                    if (want.edge_pixel == BLACK)
                        edge_total++;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_word(s_axis_tuser[0], s_axis_tdata);
        end
        mismatches    <= error_total;
        pending       <= expected_edges.size();
        results_seen  <= result_total;
        edges_seen    <= edge_total;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the first rows of a frame through the Prewitt edge threshold block,
// with random pixel textures, idle flush words and a series of thresholds
// from 0 to the full register range. An edge_checker instance predicts and
// compares.
// ----------------------------------------------------------------------------
module tb_top
    import pet_pkg::*;
();

    // The cycle limit leaves a wide margin over a clean run, for the worst
    // mix of sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT   = 60_000;
    // Extra wait once no result is pending, so words that produce none drain
    // before touching the threshold or ending the run.
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PERCENT  = 18;
    localparam int FULL_ROWS     = 5;

    // Pixel content styles for one row of the frame.
    typedef enum int {
        TEX_NOISE,
        TEX_BINARY,
        TEX_SMOOTH
    } texture_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;    // pixel[7:0]
    logic [0:0]        s_axis_tuser = '0;    // func[0]

    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // edge_pixel[7:0]
    logic              m_axis_tlast;
    logic [0:0]        m_axis_tuser;         // frame_end[0]

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int unsigned       mismatches;
    int unsigned       pending;
    int unsigned       results_seen;
    int unsigned       edges_seen;

    // When set, neither side idles; used for one long burst in the frame.
    logic              no_idle = 1'b0;
    int unsigned       cycle_count = 0;
    int unsigned       pixels_sent = 0;
    int unsigned       flushes_sent = 0;

    prewitt_edge_threshold dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    edge_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .edges_seen    (edges_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results still expected",
                     cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random, except during the burst.
    always @(posedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Presents one word and returns in the time step at which it is taken.
    // The sender may first idle at random, with tvalid low.
    task automatic send_word(input logic func, input logic [7:0] pix);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stops the sender until every expected result has arrived, then lets
    // the pipeline drain any words that produce no result.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: a setup phase, the access phase, then an idle phase so
    // that back-to-back transfers never overlap.
    task automatic apb_transfer(input logic write, input logic [THR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_EDGE_THRESHOLD, 2'b00};
        pwdata  <= write ? DATA_W'(value) : '0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Writes the threshold and reads it back; the checker compares the read.
    task automatic set_threshold(input logic [THR_W-1:0] value);
        apb_transfer(1'b1, value);
        apb_transfer(1'b0, '0);
    endtask

    // Sends pixel_total pixels of a row. Now and then an idle flush word
    // (nothing owed) is slipped in; it must produce nothing.
    task automatic send_row(input texture_t texture, input int pixel_total);
        int         level;
        int         c;
        logic [7:0] pix;
        level = int'($urandom_range(255));
        for (c = 0; c < pixel_total; c++)
        begin
            if ($urandom_range(127) == 0)
            begin
                send_word(FUNC_FLUSH, 8'($urandom));
                flushes_sent++;
            end
            case (texture)
                TEX_BINARY: pix = $urandom_range(1) ? WHITE : BLACK;
                TEX_SMOOTH:
                begin
                    level = level + int'($urandom_range(30)) - 15;
                    if (level < 0)
                        level = 0;
                    if (level > 255)
                        level = 255;
                    pix = 8'(level);
                end
                default: pix = 8'($urandom);
            endcase
            send_word(FUNC_PIXEL, pix);
            pixels_sent++;
        end
    endtask

    // Threshold for each half row from the third row on. The values reach
    // both ends of the register and the point where the strongest possible
    // Prewitt gradient just still counts as an edge.
    function automatic logic [THR_W-1:0] band_threshold(input int band);
        case (band)
            1:       return THR_W'(0);
            2:       return THR_W'(2047);
            3:       return THR_W'(805);
            4:       return THR_W'(1082);
            5:       return THR_W'(1);
            6:       return THR_W'($urandom_range(1082));
            default: return THR_W'(1024);
        endcase
    endfunction

    initial
    begin
        int       r;
        int       k;
        texture_t texture;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: the threshold must read back as its reset value,
        // and flush words with nothing owed must produce no result.
        apb_transfer(1'b0, '0);
        send_word(FUNC_FLUSH, 8'h00);
        send_word(FUNC_FLUSH, 8'hFF);
        flushes_sent += 2;

        // The first rows of a frame. Row zero uses only the extreme pixel
        // values; the others mix noise, black/white patterns and smooth
        // ramps. Row one is one long burst with no idling on either side.
        // From row two on, the sender drains the block at each half row to
        // change the threshold.
        for (r = 0; r < FULL_ROWS; r++)
        begin
            no_idle <= (r == 1);
            texture = (r == 0) ? TEX_BINARY : texture_t'($urandom_range(2));
            if (r < 2)
            begin
                send_row(texture, IMAGE_SIZE);
            end
            else
            begin
                for (k = 0; k < 2; k++)
                begin
                    settle();
                    set_threshold(band_threshold(2 * (r - 2) + k + 1));
                    send_row(texture, IMAGE_SIZE / 2);
                end
            end
        end

        // Still nothing owed: these flush words produce nothing.
        send_word(FUNC_FLUSH, 8'hFF);
        send_word(FUNC_FLUSH, 8'h00);
        flushes_sent += 2;

        // Part of one more row under a random moderate threshold.
        settle();
        set_threshold(THR_W'($urandom_range(40, 400)));
        send_row(TEX_NOISE, 100);

        settle();

        $display("Sent %0d pixel words and %0d flush words across row starts and ends;",
                 pixels_sent, flushes_sent);
        $display("checked %0d results (%0d edges) over thresholds 0 to 2047.",
                 results_seen, edges_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/pet_pkg.sv
design/pet_ram.sv
design/prewitt_edge_threshold.sv
sim/edge_checker.sv
sim/tb_top.sv
